@@ hdl/ncr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, character codes and UTF-8 helpers for the numeric character reference decoder.
package ncr_pkg;

  localparam int unsigned WIN_DEPTH = 12;

  localparam logic [20:0] CP_MAX  = 21'h10FFFF;
  localparam logic [20:0] SURR_LO = 21'h00D800;
  localparam logic [20:0] SURR_HI = 21'h00DFFF;
  localparam logic [20:0] LIM_1B  = 21'h00007F;
  localparam logic [20:0] LIM_2B  = 21'h0007FF;
  localparam logic [20:0] LIM_3B  = 21'h00FFFF;

  localparam logic [7:0] LEAD_2B = 8'hC0;
  localparam logic [7:0] LEAD_3B = 8'hE0;
  localparam logic [7:0] LEAD_4B = 8'hF0;
  localparam logic [7:0] CONT_B  = 8'h80;
  localparam logic [5:0] CONT_M  = 6'h3F;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_X_LO = 8'h78;
  localparam logic [7:0] CH_X_UP = 8'h58;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_A_LO = 8'h61;
  localparam logic [7:0] CH_F_LO = 8'h66;
  localparam logic [7:0] CH_A_UP = 8'h41;
  localparam logic [7:0] CH_F_UP = 8'h46;

  // parse phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_AMP    = 2'd1;
  localparam logic [1:0] PH_HASH   = 2'd2;
  localparam logic [1:0] PH_DIGITS = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;
  } out_t;

  typedef struct packed {
    logic feed_en;
    logic feed_input;
    logic utf_en;
    logic flush_en;
    logic close_en;
    logic close_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic close_ok;
    logic pend_zero;
    logic held_zero;
    logic feed_success;
    logic utf_done;
    logic flush_done;
  } stat_t;

  // encoded length minus one
  function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
    logic [1:0] n;
    if (cp <= LIM_1B) n = 2'd0;
    else if (cp <= LIM_2B) n = 2'd1;
    else if (cp <= LIM_3B) n = 2'd2;
    else n = 2'd3;
    return n;
  endfunction

  // rem counts down from len_m1 to 0; rem == len_m1 is the lead byte
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] len_m1,
                                           input logic [1:0] rem);
    logic [20:0] sh;
    logic [7:0]  lead;
    logic [7:0]  res;
    sh = cp >> (6 * rem);
    case (len_m1)
      2'd1:    lead = LEAD_2B;
      2'd2:    lead = LEAD_3B;
      2'd3:    lead = LEAD_4B;
      default: lead = 8'h00;
    endcase
    if (rem == len_m1) res = lead | sh[7:0];
    else res = CONT_B | {2'b00, sh[5:0] & CONT_M};
    return res;
  endfunction

endpackage

@@ hdl/ncr_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine: input accept, replay, UTF-8 emission, end-of-text flush and close.
module ncr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          text_last,
  output logic          in_ready,
  input  ncr_pkg::stat_t stat,
  output ncr_pkg::cmd_t  cmd
);

  localparam logic [2:0] ST_IN    = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_UTF   = 3'd2;
  localparam logic [2:0] ST_FLUSH = 3'd3;
  localparam logic [2:0] ST_CLOSE = 3'd4;

  logic [2:0] state, state_next;
  logic       last_flag, last_flag_next;

  always_comb begin
    state_next     = state;
    last_flag_next = last_flag;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.feed_input = (state == ST_IN);
    cmd.close_last = last_flag;
    case (state)
      ST_IN: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          cmd.feed_en    = 1'b1;
          last_flag_next = text_last;
          state_next     = stat.feed_success ? ST_UTF : ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.pend_zero) begin
          if (last_flag && !stat.held_zero) begin
            state_next = ST_FLUSH;
          end else if (stat.close_ok) begin
            cmd.close_en = 1'b1;
            state_next   = ST_IN;
          end
        end else if (stat.out_free) begin
          cmd.feed_en = 1'b1;
          if (stat.feed_success) state_next = ST_UTF;
        end
      end
      ST_UTF: begin
        if (stat.out_free) begin
          cmd.utf_en = 1'b1;
          if (stat.utf_done) state_next = ST_RUN;
        end
      end
      ST_FLUSH: begin
        if (stat.out_free) begin
          cmd.flush_en = 1'b1;
          if (stat.flush_done) state_next = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        if (stat.close_ok) begin
          cmd.close_en = 1'b1;
          state_next   = ST_IN;
        end
      end
      default: state_next = ST_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IN;
      last_flag <= 1'b0;
    end else begin
      state     <= state_next;
      last_flag <= last_flag_next;
    end
  end

endmodule

@@ hdl/ncr_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: replay window, parser registers, value accumulator, UTF-8 encoder and output stage.
module ncr_datapath #(
  parameter int unsigned MAX_DIGITS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     in_byte,
  input  ncr_pkg::cmd_t  cmd,
  output ncr_pkg::stat_t stat,
  output logic           out_valid,
  input  logic           out_ready,
  output ncr_pkg::out_t  out_data
);

  localparam logic [2:0] ACT_PASS  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_HOLD  = 3'd2;
  localparam logic [2:0] ACT_FAIL  = 3'd3;
  localparam logic [2:0] ACT_OK    = 3'd4;

  // win[0 .. held_count-1] is the candidate, then pend_count bytes wait for replay
  logic [7:0]  win [ncr_pkg::WIN_DEPTH];
  logic [3:0]  held_count, pend_count, digit_count, flush_idx;
  logic [1:0]  parse_phase;
  logic        hex_mode, value_overflow;
  logic [20:0] code_value, cp;
  logic [1:0]  utf_len_m1, utf_rem;
  logic [7:0]  sb_byte;
  logic        sb_valid;

  logic [7:0]  b;
  logic        is_dec, is_alpha, is_digit;
  logic [3:0]  dval;
  logic [24:0] cv_ext, acc_sum;
  logic        acc_ovf;
  logic [2:0]  act;
  logic [1:0]  next_phase;
  logic        set_hex, acc_en;
  logic        emit;
  logic [7:0]  emit_byte;

  assign b        = cmd.feed_input ? in_byte : win[held_count];
  assign is_dec   = b inside {[ncr_pkg::CH_0 : ncr_pkg::CH_9]};
  assign is_alpha = b inside {[ncr_pkg::CH_A_LO : ncr_pkg::CH_F_LO],
                              [ncr_pkg::CH_A_UP : ncr_pkg::CH_F_UP]};
  assign is_digit = is_dec || (hex_mode && is_alpha);
  // low nibble of 'a'/'A' is 1, so +9 gives 10
  assign dval     = is_dec ? b[3:0] : b[3:0] + 4'd9;

  assign cv_ext  = {4'b0000, code_value};
  assign acc_sum = (hex_mode ? (cv_ext << 4) : ((cv_ext << 3) + (cv_ext << 1)))
                   + {21'd0, dval};
  assign acc_ovf = acc_sum > {4'b0000, ncr_pkg::CP_MAX};

  always_comb begin
    act        = ACT_FAIL;
    next_phase = parse_phase;
    set_hex    = 1'b0;
    acc_en     = 1'b0;
    case (parse_phase)
      ncr_pkg::PH_IDLE: begin
        act = (b == ncr_pkg::CH_AMP) ? ACT_START : ACT_PASS;
      end
      ncr_pkg::PH_AMP: begin
        if (b == ncr_pkg::CH_HASH) begin
          act        = ACT_HOLD;
          next_phase = ncr_pkg::PH_HASH;
        end
      end
      ncr_pkg::PH_HASH: begin
        if (b == ncr_pkg::CH_X_LO || b == ncr_pkg::CH_X_UP) begin
          act        = ACT_HOLD;
          set_hex    = 1'b1;
          next_phase = ncr_pkg::PH_DIGITS;
        end else if (is_dec) begin
          act        = ACT_HOLD;
          acc_en     = 1'b1;
          next_phase = ncr_pkg::PH_DIGITS;
        end
      end
      default: begin
        if (is_digit) begin
          if (digit_count < 4'(MAX_DIGITS)) begin
            act    = ACT_HOLD;
            acc_en = 1'b1;
          end
        end else if (b == ncr_pkg::CH_SEMI && digit_count != 4'd0 && !value_overflow &&
                     code_value != 21'd0 &&
                     !(code_value inside {[ncr_pkg::SURR_LO : ncr_pkg::SURR_HI]})) begin
          act = ACT_OK;
        end
      end
    endcase
  end

  assign emit = (cmd.feed_en && (act == ACT_PASS || act == ACT_FAIL)) ||
                cmd.utf_en || cmd.flush_en;

  always_comb begin
    if (cmd.utf_en) emit_byte = ncr_pkg::utf8_byte(cp, utf_len_m1, utf_rem);
    else if (cmd.flush_en) emit_byte = win[flush_idx];
    else if (act == ACT_PASS) emit_byte = b;
    else emit_byte = ncr_pkg::CH_AMP;
  end

  // window contents
  always_ff @(posedge clk) begin
    if (cmd.feed_en) begin
      case (act)
        ACT_START, ACT_HOLD: begin
          if (cmd.feed_input) win[held_count] <= b;
        end
        ACT_PASS, ACT_FAIL: begin
          // drop the head; a failing input byte lands right behind the candidate
          if (!cmd.feed_input || act == ACT_FAIL) begin
            for (int i = 0; i < ncr_pkg::WIN_DEPTH - 1; i++) begin
              win[i] <= (cmd.feed_input && (4'(i + 1) == held_count)) ? b : win[i + 1];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // parser state and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count     <= '0;
      pend_count     <= '0;
      parse_phase    <= ncr_pkg::PH_IDLE;
      hex_mode       <= 1'b0;
      digit_count    <= '0;
      code_value     <= '0;
      value_overflow <= 1'b0;
      flush_idx      <= '0;
      utf_rem        <= '0;
    end else begin
      if (cmd.feed_en) begin
        case (act)
          ACT_PASS: begin
            if (!cmd.feed_input) pend_count <= pend_count - 4'd1;
          end
          ACT_START: begin
            held_count     <= 4'd1;
            parse_phase    <= ncr_pkg::PH_AMP;
            hex_mode       <= 1'b0;
            digit_count    <= '0;
            code_value     <= '0;
            value_overflow <= 1'b0;
            if (!cmd.feed_input) pend_count <= pend_count - 4'd1;
          end
          ACT_HOLD: begin
            held_count  <= held_count + 4'd1;
            parse_phase <= next_phase;
            if (set_hex) hex_mode <= 1'b1;
            if (!cmd.feed_input) pend_count <= pend_count - 4'd1;
            if (acc_en) begin
              digit_count <= digit_count + 4'd1;
              if (!value_overflow) begin
                if (acc_ovf) value_overflow <= 1'b1;
                else code_value <= acc_sum[20:0];
              end
            end
          end
          ACT_FAIL: begin
            held_count     <= '0;
            pend_count     <= cmd.feed_input ? held_count
                                             : held_count + pend_count - 4'd1;
            parse_phase    <= ncr_pkg::PH_IDLE;
            hex_mode       <= 1'b0;
            digit_count    <= '0;
            code_value     <= '0;
            value_overflow <= 1'b0;
          end
          ACT_OK: begin
            held_count     <= '0;
            pend_count     <= '0;
            parse_phase    <= ncr_pkg::PH_IDLE;
            hex_mode       <= 1'b0;
            digit_count    <= '0;
            code_value     <= '0;
            value_overflow <= 1'b0;
            utf_rem        <= ncr_pkg::utf8_len_m1(code_value);
          end
          default: ;
        endcase
      end
      if (cmd.utf_en) utf_rem <= utf_rem - 2'd1;
      if (cmd.flush_en) begin
        if (stat.flush_done) begin
          flush_idx      <= '0;
          held_count     <= '0;
          parse_phase    <= ncr_pkg::PH_IDLE;
          hex_mode       <= 1'b0;
          digit_count    <= '0;
          code_value     <= '0;
          value_overflow <= 1'b0;
        end else begin
          flush_idx <= flush_idx + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.feed_en && act == ACT_OK) begin
      cp         <= code_value;
      utf_len_m1 <= ncr_pkg::utf8_len_m1(code_value);
    end
  end

  // one byte is held back so the last beat of an item can be marked
  always_ff @(posedge clk) begin
    if (rst) begin
      sb_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        sb_byte  <= emit_byte;
        sb_valid <= 1'b1;
        if (sb_valid) begin
          out_data  <= '{out_byte: sb_byte, run_last: 1'b0, text_end: 1'b0};
          out_valid <= 1'b1;
        end else if (out_ready) begin
          out_valid <= 1'b0;
        end
      end else if (cmd.close_en && sb_valid) begin
        out_data  <= '{out_byte: sb_byte, run_last: 1'b1, text_end: cmd.close_last};
        out_valid <= 1'b1;
        sb_valid  <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.out_free     = !out_valid || out_ready;
  assign stat.close_ok     = !sb_valid || !out_valid || out_ready;
  assign stat.pend_zero    = (pend_count == 4'd0);
  assign stat.held_zero    = (held_count == 4'd0);
  assign stat.feed_success = (act == ACT_OK);
  assign stat.utf_done     = (utf_rem == 2'd0);
  assign stat.flush_done   = (flush_idx == held_count - 4'd1);

endmodule

@@ hdl/numeric_char_ref_to_utf8_core.sv @@
`timescale 1ns / 1ps
// Top level of the numeric character reference to UTF-8 decoder.
//
//   channel | signals                          | beat
//   --------+----------------------------------+---------------------------------
//   input   | in_valid, in_ready, in_data      | one text byte and its last mark
//   output  | out_valid, out_ready, out_data   | one decoded byte, run/text end
//
// A byte that needs no replay is accepted, then its results are closed.
// A failed candidate adds a replay step per replayed byte, a decoded reference
// an emission per UTF-8 byte, and end of text a flush per held byte and a close.
// Any cycle that produces a byte waits until the output register can be loaded.
// Reset is synchronous and clears all counts and parser state; window bytes are
// not cleared, only written entries are read.
module numeric_char_ref_to_utf8_core #(
  parameter int unsigned MAX_DIGITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ncr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ncr_pkg::out_t out_data
);

  ncr_pkg::cmd_t  cmd;
  ncr_pkg::stat_t stat;

  ncr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .text_last (in_data.text_last),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ncr_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (in_data.in_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
